// File: sv/resistive_touch_point_filter_assert.svh
// Assertion macros for the touch point filter; clk and rst_n come from the using module.
`ifndef RESISTIVE_TOUCH_POINT_FILTER_ASSERT_SVH
`define RESISTIVE_TOUCH_POINT_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

`define RTPF_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`define RTPF_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`else

`define RTPF_ASSERT_IMP(label, cond, expr, msg)

`define RTPF_ASSERT_NEXT(label, cond, expr, msg)

`endif

`endif

// File: sv/rtpf_pkg.sv
// Shared constants, types and helpers for the touch point filter.
package rtpf_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    localparam int SAMPLE_W = 12;
    localparam int ORIENT_W = 3;
    localparam int PX_W     = 9;
    localparam int PY_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int X_TOP = SCREEN_WIDTH - 1;
    localparam int Y_TOP = SCREEN_HEIGHT - 1;
    localparam int SCREEN_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    // quotient never exceeds the top coordinate
    localparam int QW    = $clog2(SCREEN_MAX);
    localparam int NUM_W = SAMPLE_W + QW;

    localparam logic [SAMPLE_W-1:0] X_LOW_RESET     = SAMPLE_W'(200);
    localparam logic [SAMPLE_W-1:0] X_HIGH_RESET    = SAMPLE_W'(3800);
    localparam logic [SAMPLE_W-1:0] Y_LOW_RESET     = SAMPLE_W'(240);
    localparam logic [SAMPLE_W-1:0] Y_HIGH_RESET    = SAMPLE_W'(3700);
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(80);

    localparam int ORIENT_SWAP     = 0;
    localparam int ORIENT_MIRROR_X = 1;
    localparam int ORIENT_MIRROR_Y = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLED,
        CFG_X_LOW,
        CFG_X_HIGH,
        CFG_Y_LOW,
        CFG_Y_HIGH,
        CFG_THRESHOLD,
        CFG_ORIENTATION
    } cfg_index_t;

    typedef struct packed {
        logic ok;
        logic touch;
        logic empty_x;
        logic empty_y;
    } item_flags_t;

    function automatic logic [SAMPLE_W-1:0] mid3(
        input logic [SAMPLE_W-1:0] p,
        input logic [SAMPLE_W-1:0] q,
        input logic [SAMPLE_W-1:0] r
    );
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        if (r <= lo) begin
            return lo;
        end
        if (r >= hi) begin
            return hi;
        end
        return r;
    endfunction

endpackage

// File: sv/rtpf_meas_if.sv
// Measurement round channel: three samples per axis and the interrupt level.
interface rtpf_meas_if
    import rtpf_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] x_sample_a;
    logic [SAMPLE_W-1:0] x_sample_b;
    logic [SAMPLE_W-1:0] x_sample_c;
    logic [SAMPLE_W-1:0] y_sample_a;
    logic [SAMPLE_W-1:0] y_sample_b;
    logic [SAMPLE_W-1:0] y_sample_c;
    logic [SAMPLE_W-1:0] z_sample_a;
    logic [SAMPLE_W-1:0] z_sample_b;
    logic [SAMPLE_W-1:0] z_sample_c;
    logic                irq_active;

    modport source (
        output valid, x_sample_a, x_sample_b, x_sample_c, y_sample_a, y_sample_b,
               y_sample_c, z_sample_a, z_sample_b, z_sample_c, irq_active,
        input  ready
    );
    modport sink (
        input  valid, x_sample_a, x_sample_b, x_sample_c, y_sample_a, y_sample_b,
               y_sample_c, z_sample_a, z_sample_b, z_sample_c, irq_active,
        output ready
    );
endinterface

// File: sv/rtpf_result_if.sv
// Result channel: status flags and the mapped screen point.
interface rtpf_result_if
    import rtpf_pkg::*;
;
    logic            valid;
    logic            ready;
    logic            read_ok;
    logic            touching;
    logic [PX_W-1:0] point_x;
    logic [PY_W-1:0] point_y;

    modport source (
        output valid, read_ok, touching, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, read_ok, touching, point_x, point_y,
        output ready
    );
endinterface

// File: sv/resistive_touch_point_filter.sv
// Resistive touch point filter: median, press detection and window mapping pipeline.
//
// Usage: one measurement round (three raw samples each of X, Y and pressure plus
// the interrupt level) enters on the meas channel per transfer; one result
// (read_ok, touching, point_x, point_y) leaves on the result channel per round.
// Configuration registers are written through cfg_we / cfg_index / cfg_data while
// no round is in flight; a write to an index past the orientation register is
// ignored.
// Throughput: one round per cycle while the receiver takes results. The pipeline
// holds the median stage, the mapping stage, the constant multiply, one restoring
// divide stage per quotient bit and the output register.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the default
// calibration with the block disabled.
// When the receiver stalls, the result holds in the output register and
// bubbles ahead of it still close up, so rounds keep being taken until every
// stage holds a round; ready then drops until the result is taken.
module resistive_touch_point_filter
    import rtpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rtpf_meas_if.sink             meas,
    rtpf_result_if.source         result
);

    localparam int ST_MED  = 0;
    localparam int ST_MAP  = 1;
    localparam int ST_MUL  = 2;
    localparam int ST_DIV0 = 3;
    localparam int ST_OUT  = ST_DIV0 + QW;
    localparam int NST     = ST_OUT + 1;

    // configuration registers
    logic                enabled_reg;
    logic [SAMPLE_W-1:0] x_low_reg;
    logic [SAMPLE_W-1:0] x_high_reg;
    logic [SAMPLE_W-1:0] y_low_reg;
    logic [SAMPLE_W-1:0] y_high_reg;
    logic [SAMPLE_W-1:0] thr_reg;
    logic [ORIENT_W-1:0] orient_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            x_low_reg   <= X_LOW_RESET;
            x_high_reg  <= X_HIGH_RESET;
            y_low_reg   <= Y_LOW_RESET;
            y_high_reg  <= Y_HIGH_RESET;
            thr_reg     <= THRESHOLD_RESET;
            orient_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ENABLED:     enabled_reg <= cfg_data[0];
                CFG_X_LOW:       x_low_reg   <= cfg_data[SAMPLE_W-1:0];
                CFG_X_HIGH:      x_high_reg  <= cfg_data[SAMPLE_W-1:0];
                CFG_Y_LOW:       y_low_reg   <= cfg_data[SAMPLE_W-1:0];
                CFG_Y_HIGH:      y_high_reg  <= cfg_data[SAMPLE_W-1:0];
                CFG_THRESHOLD:   thr_reg     <= cfg_data[SAMPLE_W-1:0];
                CFG_ORIENTATION: orient_reg  <= cfg_data[ORIENT_W-1:0];
                default:         ;
            endcase
        end
    end

    // stage valids and per-stage advance enables
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || result.ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign meas.ready = en[ST_MED];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= meas.valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // median stage
    logic [SAMPLE_W-1:0] med_x_reg;
    logic [SAMPLE_W-1:0] med_y_reg;
    logic [SAMPLE_W-1:0] med_z_reg;
    logic                med_irq_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_MED])
        begin
            med_x_reg   <= mid3(meas.x_sample_a, meas.x_sample_b, meas.x_sample_c);
            med_y_reg   <= mid3(meas.y_sample_a, meas.y_sample_b, meas.y_sample_c);
            med_z_reg   <= mid3(meas.z_sample_a, meas.z_sample_b, meas.z_sample_c);
            med_irq_reg <= meas.irq_active;
        end
    end

    // press detection, swap, clamp and offset
    logic [SAMPLE_W-1:0] win_lo [2];
    logic [SAMPLE_W-1:0] win_hi [2];
    logic [SAMPLE_W-1:0] axv    [2];
    logic [SAMPLE_W-1:0] clampv [2];
    logic [SAMPLE_W-1:0] dif_next [2];
    logic [SAMPLE_W-1:0] den_next [2];
    logic                empty_next [2];
    logic                press;
    item_flags_t         map_flag_next;

    always_comb
    begin
        win_lo[0] = x_low_reg;
        win_hi[0] = x_high_reg;
        win_lo[1] = y_low_reg;
        win_hi[1] = y_high_reg;
        axv[0] = orient_reg[ORIENT_SWAP] ? med_y_reg : med_x_reg;
        axv[1] = orient_reg[ORIENT_SWAP] ? med_x_reg : med_y_reg;
        for (int a = 0; a < 2; a++)
        begin
            empty_next[a] = win_hi[a] <= win_lo[a];
            if (axv[a] < win_lo[a])
            begin
                clampv[a] = win_lo[a];
            end
            else if (axv[a] > win_hi[a])
            begin
                clampv[a] = win_hi[a];
            end
            else
            begin
                clampv[a] = axv[a];
            end
            dif_next[a] = clampv[a] - win_lo[a];
            den_next[a] = win_hi[a] - win_lo[a];
        end
        press = (med_z_reg >= thr_reg) || (med_irq_reg && (med_z_reg >= (thr_reg >> 1)));
        map_flag_next.ok      = enabled_reg;
        map_flag_next.touch   = enabled_reg && press;
        map_flag_next.empty_x = empty_next[0];
        map_flag_next.empty_y = empty_next[1];
    end

    logic [SAMPLE_W-1:0] map_dif_reg [2];
    logic [SAMPLE_W-1:0] map_den_reg [2];
    item_flags_t         map_flag_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_MAP])
        begin
            map_dif_reg  <= dif_next;
            map_den_reg  <= den_next;
            map_flag_reg <= map_flag_next;
        end
    end

    // scale offset by the top coordinate
    logic [NUM_W-1:0]    mul_num_reg [2];
    logic [SAMPLE_W-1:0] mul_den_reg [2];
    item_flags_t         mul_flag_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            mul_num_reg[0] <= NUM_W'(map_dif_reg[0]) * NUM_W'(X_TOP);
            mul_num_reg[1] <= NUM_W'(map_dif_reg[1]) * NUM_W'(Y_TOP);
            mul_den_reg    <= map_den_reg;
            mul_flag_reg   <= map_flag_reg;
        end
    end

    // restoring divide, one quotient bit per stage, most significant first
    logic [NUM_W-1:0]    rem_reg [2][QW];
    logic [QW-1:0]       quo_reg [2][QW];
    logic [SAMPLE_W-1:0] dden_reg [2][QW];
    item_flags_t         div_flag_reg [QW];

    for (genvar a = 0; a < 2; a++)
    begin : g_axis
        for (genvar k = 0; k < QW; k++)
        begin : g_bit
            localparam int BIT = QW - 1 - k;
            logic [NUM_W-1:0]    r_in;
            logic [NUM_W-1:0]    r_out;
            logic [NUM_W-1:0]    dsh;
            logic [QW-1:0]       q_in;
            logic [QW-1:0]       q_out;
            logic [SAMPLE_W-1:0] d_in;

            if (k == 0)
            begin : g_first
                assign r_in = mul_num_reg[a];
                assign q_in = '0;
                assign d_in = mul_den_reg[a];
            end
            else
            begin : g_rest
                assign r_in = rem_reg[a][k-1];
                assign q_in = quo_reg[a][k-1];
                assign d_in = dden_reg[a][k-1];
            end

            always_comb
            begin
                dsh = NUM_W'(d_in) << BIT;
                if (r_in >= dsh)
                begin
                    r_out = r_in - dsh;
                    q_out = q_in | (QW'(1) << BIT);
                end
                else
                begin
                    r_out = r_in;
                    q_out = q_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[ST_DIV0+k])
                begin
                    rem_reg[a][k]  <= r_out;
                    quo_reg[a][k]  <= q_out;
                    dden_reg[a][k] <= d_in;
                end
            end
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_flag
        always_ff @(posedge clk)
        begin
            if (en[ST_DIV0+k])
            begin
                div_flag_reg[k] <= (k == 0) ? mul_flag_reg : div_flag_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // empty window, mirror and output register
    logic [QW-1:0]   sx;
    logic [QW-1:0]   sy;
    item_flags_t     fin_flag;
    logic            out_ok_reg;
    logic            out_touch_reg;
    logic [PX_W-1:0] out_x_reg;
    logic [PY_W-1:0] out_y_reg;

    always_comb
    begin
        fin_flag = div_flag_reg[QW-1];
        sx = fin_flag.empty_x ? '0 : quo_reg[0][QW-1];
        sy = fin_flag.empty_y ? '0 : quo_reg[1][QW-1];
        if (orient_reg[ORIENT_MIRROR_X])
        begin
            sx = QW'(X_TOP) - sx;
        end
        if (orient_reg[ORIENT_MIRROR_Y])
        begin
            sy = QW'(Y_TOP) - sy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            out_ok_reg    <= fin_flag.ok;
            out_touch_reg <= fin_flag.touch;
            out_x_reg     <= fin_flag.touch ? PX_W'(sx) : '0;
            out_y_reg     <= fin_flag.touch ? PY_W'(sy) : '0;
        end
    end

    assign result.valid    = vld_reg[ST_OUT];
    assign result.read_ok  = out_ok_reg;
    assign result.touching = out_touch_reg;
    assign result.point_x  = out_x_reg;
    assign result.point_y  = out_y_reg;

`include "resistive_touch_point_filter_assert.svh"

    `RTPF_ASSERT_IMP(a_touch_needs_ok, result.valid && result.touching, result.read_ok,
        "touch reported without a valid read")
    `RTPF_ASSERT_IMP(a_idle_point_zero, result.valid && !result.touching,
        (result.point_x == '0) && (result.point_y == '0), "nonzero point without a touch")
    `RTPF_ASSERT_IMP(a_empty_out_ready, !result.valid, meas.ready,
        "input stalled while the output register is empty")
    `RTPF_ASSERT_NEXT(a_accept_enters, meas.valid && meas.ready, vld_reg[ST_MED],
        "accepted round missing from the median stage")

endmodule

// File: bench/touch_point_monitor.sv
`timescale 1ns / 1ps
// Touch point monitor: tracks both channels, predicts each screen point and compares.
module touch_point_monitor
    import rtpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    rtpf_meas_if                  meas,
    rtpf_result_if                result,
    output int                    rounds_open,
    output int                    fail_count
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] xa;
        logic [SAMPLE_W-1:0] xb;
        logic [SAMPLE_W-1:0] xc;
        logic [SAMPLE_W-1:0] ya;
        logic [SAMPLE_W-1:0] yb;
        logic [SAMPLE_W-1:0] yc;
        logic [SAMPLE_W-1:0] za;
        logic [SAMPLE_W-1:0] zb;
        logic [SAMPLE_W-1:0] zc;
        logic                irq;
    } touch_round_t;

    typedef struct packed {
        logic            read_ok;
        logic            touching;
        logic [PX_W-1:0] px;
        logic [PY_W-1:0] py;
    } touch_point_t;

    logic                en_q;
    logic [SAMPLE_W-1:0] xl_q;
    logic [SAMPLE_W-1:0] xh_q;
    logic [SAMPLE_W-1:0] yl_q;
    logic [SAMPLE_W-1:0] yh_q;
    logic [SAMPLE_W-1:0] thr_q;
    logic [ORIENT_W-1:0] orient_q;

    touch_point_t expected_points[$];

    // Shadow copy of the calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_q     <= 1'b0;
            xl_q     <= X_LOW_RESET;
            xh_q     <= X_HIGH_RESET;
            yl_q     <= Y_LOW_RESET;
            yh_q     <= Y_HIGH_RESET;
            thr_q    <= THRESHOLD_RESET;
            orient_q <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLED:     en_q     <= cfg_data[0];
                CFG_X_LOW:       xl_q     <= cfg_data[SAMPLE_W-1:0];
                CFG_X_HIGH:      xh_q     <= cfg_data[SAMPLE_W-1:0];
                CFG_Y_LOW:       yl_q     <= cfg_data[SAMPLE_W-1:0];
                CFG_Y_HIGH:      yh_q     <= cfg_data[SAMPLE_W-1:0];
                CFG_THRESHOLD:   thr_q    <= cfg_data[SAMPLE_W-1:0];
                CFG_ORIENTATION: orient_q <= cfg_data[ORIENT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Median as sum less the extremes
    function automatic int median_of(input int a, input int b, input int c);
        int lo;
        int hi;
        lo = a;
        hi = a;
        if (b < lo) lo = b;
        if (c < lo) lo = c;
        if (b > hi) hi = b;
        if (c > hi) hi = c;
        return a + b + c - lo - hi;
    endfunction

    function automatic int scale_to_screen(input int raw, input int lo, input int hi,
                                           input int top);
        int v;
        if (hi <= lo)
        begin
            return 0;
        end
        v = raw;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return ((v - lo) * top) / (hi - lo);
    endfunction

    function automatic touch_point_t map_touch_point(input touch_round_t r);
        touch_point_t p;
        int           mx;
        int           my;
        int           mz;
        int           ax;
        int           ay;
        int           sx;
        int           sy;
        logic         pressed;
        p = '0;
        if (!en_q)
        begin
            return p;
        end
        p.read_ok = 1'b1;
        mx = median_of(int'(r.xa), int'(r.xb), int'(r.xc));
        my = median_of(int'(r.ya), int'(r.yb), int'(r.yc));
        mz = median_of(int'(r.za), int'(r.zb), int'(r.zc));
        pressed = (mz >= int'(thr_q)) || (r.irq && (mz >= int'(thr_q >> 1)));
        if (!pressed)
        begin
            return p;
        end
        ax = orient_q[ORIENT_SWAP] ? my : mx;
        ay = orient_q[ORIENT_SWAP] ? mx : my;
        sx = scale_to_screen(ax, int'(xl_q), int'(xh_q), X_TOP);
        sy = scale_to_screen(ay, int'(yl_q), int'(yh_q), Y_TOP);
        if (orient_q[ORIENT_MIRROR_X]) sx = X_TOP - sx;
        if (orient_q[ORIENT_MIRROR_Y]) sy = Y_TOP - sy;
        p.touching = 1'b1;
        p.px = PX_W'(sx);
        p.py = PY_W'(sy);
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track_points
        touch_round_t r;
        touch_point_t want;
        touch_point_t got;
        int           pushed;
        int           popped;
        int           errs;
        if (!rst_n)
        begin
            rounds_open <= 0;
            fail_count  <= 0;
            expected_points.delete();
        end
        else
        begin
            pushed = 0;
            popped = 0;
            errs   = 0;
            if (result.valid && result.ready)
            begin
                got = {result.read_ok, result.touching, result.point_x, result.point_y};
                if (expected_points.size() == 0)
                begin
                    errs = 1;
                    if (fail_count < 10)
                        $display("%0t: unexpected point ok=%0d touch=%0d x=%0d y=%0d",
                                 $realtime, got.read_ok, got.touching, got.px, got.py);
                end
                else
                begin
                    popped = 1;
                    want = expected_points.pop_front();
                    if (got.read_ok !== want.read_ok || got.touching !== want.touching ||
                        got.px !== want.px || got.py !== want.py)
                    begin
                        errs = 1;
                        if (fail_count < 10)
                            $display({"%0t: point mismatch: expected ok=%0d touch=%0d x=%0d ",
                                      "y=%0d, got ok=%0d touch=%0d x=%0d y=%0d"},
                                     $realtime, want.read_ok, want.touching, want.px,
                                     want.py, got.read_ok, got.touching, got.px, got.py);
                    end
                end
            end
            if (meas.valid && meas.ready)
            begin
                r = {meas.x_sample_a, meas.x_sample_b, meas.x_sample_c,
                     meas.y_sample_a, meas.y_sample_b, meas.y_sample_c,
                     meas.z_sample_a, meas.z_sample_b, meas.z_sample_c, meas.irq_active};
                expected_points.push_back(map_touch_point(r));
                pushed = 1;
            end
            rounds_open <= rounds_open + pushed - popped;
            fail_count  <= fail_count + errs;
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the touch point filter bench: clock, reset, calibration writes and round stimulus.
module tb_top;
    import rtpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_PHASES  = 13;
    localparam int PHASE_ROUNDS   = 110;
    localparam int SAMPLE_MAX     = 4095;

    typedef struct packed {
        logic [SAMPLE_W-1:0] xa;
        logic [SAMPLE_W-1:0] xb;
        logic [SAMPLE_W-1:0] xc;
        logic [SAMPLE_W-1:0] ya;
        logic [SAMPLE_W-1:0] yb;
        logic [SAMPLE_W-1:0] yc;
        logic [SAMPLE_W-1:0] za;
        logic [SAMPLE_W-1:0] zb;
        logic [SAMPLE_W-1:0] zc;
        logic                irq;
    } touch_round_t;

    typedef struct packed {
        logic                en;
        logic [SAMPLE_W-1:0] xl;
        logic [SAMPLE_W-1:0] xh;
        logic [SAMPLE_W-1:0] yl;
        logic [SAMPLE_W-1:0] yh;
        logic [SAMPLE_W-1:0] thr;
        logic [ORIENT_W-1:0] orient;
    } panel_cal_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  steady;
    int                    rounds_open;
    int                    fail_count;
    int                    quiet_cycles;

    rtpf_meas_if   meas_ch();
    rtpf_result_if result_ch();

    resistive_touch_point_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .meas      (meas_ch),
        .result    (result_ch)
    );

    touch_point_monitor monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .meas        (meas_ch),
        .result      (result_ch),
        .rounds_open (rounds_open),
        .fail_count  (fail_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SAMPLE_W'(SAMPLE_MAX);
            default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    // Three samples whose median is mid, in random order
    function automatic logic [3*SAMPLE_W-1:0] triple_around(input int mid, input int spread);
        int                  dl;
        int                  dh;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] m;
        dl = (mid < spread) ? mid : spread;
        dh = ((SAMPLE_MAX - mid) < spread) ? SAMPLE_MAX - mid : spread;
        m  = SAMPLE_W'(mid);
        lo = SAMPLE_W'(mid - int'($urandom_range(0, dl)));
        hi = SAMPLE_W'(mid + int'($urandom_range(0, dh)));
        case ($urandom_range(0, 5))
            0:       return {lo, m, hi};
            1:       return {lo, hi, m};
            2:       return {m, lo, hi};
            3:       return {m, hi, lo};
            4:       return {hi, lo, m};
            default: return {hi, m, lo};
        endcase
    endfunction

    function automatic touch_round_t flat_round(input int x, input int y, input int z,
                                                input logic irq);
        touch_round_t r;
        r.xa = SAMPLE_W'(x);
        r.xb = SAMPLE_W'(x);
        r.xc = SAMPLE_W'(x);
        r.ya = SAMPLE_W'(y);
        r.yb = SAMPLE_W'(y);
        r.yc = SAMPLE_W'(y);
        r.za = SAMPLE_W'(z);
        r.zb = SAMPLE_W'(z);
        r.zc = SAMPLE_W'(z);
        r.irq = irq;
        return r;
    endfunction

    function automatic touch_round_t random_round(input panel_cal_t c);
        touch_round_t r;
        int           spread;
        int           zmid;
        if ($urandom_range(0, 4) == 0)
        begin
            r = {rand_sample(), rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                 rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                 1'($urandom_range(0, 1))};
            return r;
        end
        spread = ($urandom_range(0, 5) == 0) ? SAMPLE_MAX : $urandom_range(0, 30);
        {r.xa, r.xb, r.xc} = triple_around($urandom_range(0, SAMPLE_MAX), spread);
        spread = ($urandom_range(0, 5) == 0) ? SAMPLE_MAX : $urandom_range(0, 30);
        {r.ya, r.yb, r.yc} = triple_around($urandom_range(0, SAMPLE_MAX), spread);
        // Aim the pressure median at the full and half thresholds
        case ($urandom_range(0, 6))
            0:       zmid = int'(c.thr);
            1:       zmid = int'(c.thr) - 1;
            2:       zmid = int'(c.thr >> 1);
            3:       zmid = int'(c.thr >> 1) - 1;
            4:       zmid = $urandom_range(int'(c.thr), SAMPLE_MAX);
            default: zmid = $urandom_range(0, SAMPLE_MAX);
        endcase
        if (zmid < 0) zmid = 0;
        {r.za, r.zb, r.zc} = triple_around(zmid, $urandom_range(0, 40));
        r.irq = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic logic [2*SAMPLE_W-1:0] random_window();
        int lo;
        int hi;
        case ($urandom_range(0, 7))
            0:
            begin
                lo = $urandom_range(0, SAMPLE_MAX);
                hi = lo;
            end
            1:
            begin
                lo = $urandom_range(1, SAMPLE_MAX);
                hi = $urandom_range(0, lo - 1);
            end
            2:
            begin
                lo = 0;
                hi = SAMPLE_MAX;
            end
            3:
            begin
                lo = $urandom_range(0, SAMPLE_MAX - 8);
                hi = lo + int'($urandom_range(1, 8));
            end
            4:
            begin
                lo = $urandom_range(0, SAMPLE_MAX);
                hi = $urandom_range(0, SAMPLE_MAX);
            end
            default:
            begin
                lo = $urandom_range(0, 600);
                hi = $urandom_range(3300, SAMPLE_MAX);
            end
        endcase
        return {SAMPLE_W'(lo), SAMPLE_W'(hi)};
    endfunction

    function automatic panel_cal_t random_calibration();
        panel_cal_t c;
        c.en = ($urandom_range(0, 7) != 0);
        {c.xl, c.xh} = random_window();
        {c.yl, c.yh} = random_window();
        case ($urandom_range(0, 7))
            0:       c.thr = '0;
            1:       c.thr = SAMPLE_W'(SAMPLE_MAX);
            2:       c.thr = SAMPLE_W'(1);
            default: c.thr = SAMPLE_W'($urandom_range(0, 2000));
        endcase
        c.orient = ORIENT_W'($urandom_range(0, 7));
        return c;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_calibration(input panel_cal_t c);
        write_reg(CFG_ENABLED, CFG_DATA_W'(c.en));
        write_reg(CFG_X_LOW, c.xl);
        write_reg(CFG_X_HIGH, c.xh);
        write_reg(CFG_Y_LOW, c.yl);
        write_reg(CFG_Y_HIGH, c.yh);
        write_reg(CFG_THRESHOLD, c.thr);
        write_reg(CFG_ORIENTATION, CFG_DATA_W'(c.orient));
        cfg_we <= 1'b0;
    endtask

    // Called at the edge of the previous transfer, or when the channel is idle
    task automatic apply_round(input touch_round_t r);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            meas_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        meas_ch.valid      <= 1'b1;
        meas_ch.x_sample_a <= r.xa;
        meas_ch.x_sample_b <= r.xb;
        meas_ch.x_sample_c <= r.xc;
        meas_ch.y_sample_a <= r.ya;
        meas_ch.y_sample_b <= r.yb;
        meas_ch.y_sample_c <= r.yc;
        meas_ch.z_sample_a <= r.za;
        meas_ch.z_sample_b <= r.zb;
        meas_ch.z_sample_c <= r.zc;
        meas_ch.irq_active <= r.irq;
        do @(posedge clk); while (!meas_ch.ready);
    endtask

    task automatic wait_drained();
        meas_ch.valid <= 1'b0;
        do @(posedge clk); while (rounds_open != 0);
    endtask

    initial
    begin : stimulus
        panel_cal_t   cal;
        touch_round_t r;
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_ENABLED;
        cfg_data           <= '0;
        meas_ch.valid      <= 1'b0;
        meas_ch.x_sample_a <= '0;
        meas_ch.x_sample_b <= '0;
        meas_ch.x_sample_c <= '0;
        meas_ch.y_sample_a <= '0;
        meas_ch.y_sample_b <= '0;
        meas_ch.y_sample_c <= '0;
        meas_ch.z_sample_a <= '0;
        meas_ch.z_sample_b <= '0;
        meas_ch.z_sample_c <= '0;
        meas_ch.irq_active <= 1'b0;
        steady = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset calibration leaves the block disabled
        apply_round(flat_round(4095, 4095, 4095, 1'b1));
        apply_round(flat_round(2000, 2000, 2000, 1'b0));
        wait_drained();

        cal = '{1'b1, X_LOW_RESET, X_HIGH_RESET, Y_LOW_RESET, Y_HIGH_RESET,
                THRESHOLD_RESET, 3'd0};
        load_calibration(cal);
        apply_round(flat_round(0, 0, 0, 1'b0));
        apply_round(flat_round(4095, 4095, 4095, 1'b1));
        apply_round(flat_round(100, 100, 80, 1'b0));
        apply_round(flat_round(2000, 2000, 79, 1'b0));
        apply_round(flat_round(2000, 2000, 40, 1'b1));
        apply_round(flat_round(2000, 2000, 39, 1'b1));
        apply_round(flat_round(2000, 2000, 40, 1'b0));
        r = '{12'd3000, 12'd100, 12'd2000, 12'd500, 12'd3500, 12'd1000,
              12'd4095, 12'd0, 12'd500, 1'b0};
        apply_round(r);
        r = '{12'd2000, 12'd2000, 12'd100, 12'd10, 12'd4000, 12'd4000,
              12'd90, 12'd90, 12'd3000, 1'b1};
        apply_round(r);

        // Each swap and mirror combination
        for (int o = 0; o < 8; o++)
        begin
            wait_drained();
            cal.orient = ORIENT_W'(o);
            load_calibration(cal);
            apply_round(flat_round(1000, 3000, 2000, 1'b0));
        end

        // Empty and inverted windows with both axes mirrored
        wait_drained();
        cal = '{1'b1, 12'd1000, 12'd1000, 12'd3000, 12'd100, 12'd80, 3'd6};
        load_calibration(cal);
        apply_round(flat_round(1500, 1500, 500, 1'b0));

        // Full windows with the threshold at its extremes
        wait_drained();
        cal = '{1'b1, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 3'd0};
        load_calibration(cal);
        apply_round(flat_round(4095, 0, 0, 1'b0));
        wait_drained();
        cal.thr = 12'd4095;
        load_calibration(cal);
        apply_round(flat_round(2048, 4095, 4095, 1'b0));
        apply_round(flat_round(2048, 1024, 2047, 1'b1));
        apply_round(flat_round(2048, 1024, 2046, 1'b1));
        wait_drained();
        cal.thr = 12'd1;
        load_calibration(cal);
        apply_round(flat_round(3000, 3000, 0, 1'b1));
        apply_round(flat_round(3000, 3000, 0, 1'b0));

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_drained();
            cal = random_calibration();
            if (ph == 0)
                cal.en = 1'b1;
            load_calibration(cal);
            for (int n = 0; n < PHASE_ROUNDS; n++)
            begin
                if (n % 40 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                // Hold off once until every result is back
                if (ph == RANDOM_PHASES / 2 && n == PHASE_ROUNDS / 2)
                    wait_drained();
                apply_round(random_round(cal));
            end
        end

        steady = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    // Watchdog: count cycles with no transfer and no register write
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((meas_ch.valid && meas_ch.ready) || (result_ch.valid && result_ch.ready) ||
                 cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
